>>> rtl/fixed_block_pool_allocator_assert.svh
// Assertion macros used by the block's checker.
`ifndef FIXED_BLOCK_POOL_ALLOCATOR_ASSERT_SVH
`define FIXED_BLOCK_POOL_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, checked out of reset
`define FBPA_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("fbpa assertion failed");

// Next-cycle implication, checked out of reset
`define FBPA_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("fbpa assertion failed");

`endif

>>> rtl/fbpa_pkg.sv
// Types and constants of the fixed block pool allocator.
package fbpa_pkg;

  // Field widths
  localparam int unsigned CNT_W      = 11;  // block_count, free count, ring pointers
  localparam int unsigned SIZE_W     = 16;  // block_size
  localparam int unsigned ENTRY_W    = 10;  // one ring entry, block_number
  localparam int unsigned OFFSET_W   = 26;  // block_offset
  localparam int unsigned STATUS_W   = 3;
  localparam int unsigned IN_DATA_W  = 32;  // byte_offset
  localparam int unsigned IN_USER_W  = 2;   // mode, is_null
  localparam int unsigned OUT_DATA_W = 56;  // 50 field bits padded to bytes
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  // Divider: one quotient bit per step
  localparam int unsigned DIV_STEPS  = 32;
  localparam int unsigned STEP_W     = 5;

  // Register reset values
  localparam logic [CNT_W-1:0]  BLOCK_COUNT_RST = 11'd1024;
  localparam logic [SIZE_W-1:0] BLOCK_SIZE_RST  = 16'd64;
  localparam logic [SIZE_W-1:0] MIN_SIZE        = 16'd2;
  localparam logic [CNT_W-1:0]  MIN_COUNT       = 11'd2;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BLOCK_COUNT = 2'd0,
    REG_BLOCK_SIZE  = 2'd1
  } reg_idx_e;

  // Request kinds
  typedef enum logic {
    MODE_ALLOC = 1'b0,
    MODE_FREE  = 1'b1
  } mode_e;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 3'd0,
    ST_EMPTY      = 3'd1,
    ST_MISALIGNED = 3'd2,
    ST_RANGE      = 3'd3,
    ST_NULL       = 3'd4,
    ST_FULL       = 3'd5
  } status_e;

  // Sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_RESULT
  } state_e;

endpackage

>>> rtl/fixed_block_pool_allocator.sv
// Fixed-size block pool allocator: free-index ring in a synchronous memory.
//
// An allocate request or a null free goes from acceptance to the S_RESULT
// state, which checks it and commits its result to the output register. A
// free request that is not null has its operand loaded at acceptance, then
// runs 32 steps of the one-bit-per-cycle restoring divider (S_DIV) that splits
// the byte offset into block index and remainder, then checks and commits in
// S_RESULT. One request is in flight at a time. A new one is accepted once the
// previous result sits in the output register, even if it is not yet taken.
// A stalled output holds the next result back in S_RESULT. The ring memory is
// read at the head every cycle and written at the tail on a free commit. Head
// data is used only from the cycle after acceptance, so the next request
// always sees a write made at a commit edge. After reset or a configuration
// write the ring counts as 0..N-1 without a clearing pass: a fill mark records
// how many entries have been written since, and an entry beyond it reads as
// its own position. Configuration is taken only when no request is in flight,
// and a pending configuration write holds off new requests.
module fixed_block_pool_allocator
  import fbpa_pkg::*;
#(
  parameter int unsigned MAX_BLOCKS = 1024
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // request stream
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata_i,   // [31:0] byte_offset
  input  logic [IN_USER_W-1:0]  s_axis_tuser_i,   // [0] mode, [1] is_null
  // result stream
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  output logic [OUT_DATA_W-1:0] m_axis_tdata_o,   // [25:0] block_offset,
                                                  // [35:26] block_number,
                                                  // [38:36] status,
                                                  // [49:39] free_left, rest 0
  // configuration writes
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned AW      = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int unsigned NMAX    = (MAX_BLOCKS > 2047) ? 2047 : MAX_BLOCKS;
  localparam logic [CNT_W-1:0] NMAX_C    = CNT_W'(NMAX);
  localparam logic [CNT_W-1:0] RST_COUNT =
    CNT_W'((NMAX < 1024) ? NMAX : 1024);

  // Effective block count, saturated into [2, pool depth]
  function automatic logic [CNT_W-1:0] eff_count(input logic [CNT_W-1:0] bc);
    logic [CNT_W-1:0] n;
    n = bc;
    if (n < MIN_COUNT) n = MIN_COUNT;
    if (n > NMAX_C) n = NMAX_C;
    return n;
  endfunction

  // Registers
  state_e              state_q, state_d;
  logic [CNT_W-1:0]    block_count_q, block_count_d;
  logic [SIZE_W-1:0]   block_size_q, block_size_d;
  logic [CNT_W-1:0]    head_q, head_d;
  logic [CNT_W-1:0]    count_q, count_d;
  logic [CNT_W-1:0]    fill_q, fill_d;
  logic                out_valid_q, out_valid_d;
  logic [OUT_DATA_W-1:0] out_data_q, out_data_d;
  logic                mode_q, null_q, neg_q;
  logic [SIZE_W-1:0]   rem_q, rem_d;
  logic [IN_DATA_W-1:0] quo_q, quo_d;
  logic [STEP_W-1:0]   step_q, step_d;

  // Ring memory
  logic [ENTRY_W-1:0]  ring_mem [MAX_BLOCKS];
  logic [ENTRY_W-1:0]  mem_rdata_q;
  logic                mem_we;
  logic [AW-1:0]       mem_waddr;
  logic [ENTRY_W-1:0]  mem_wdata;

  // Combinational helpers
  logic                in_acc, cfg_acc, commit;
  logic [CNT_W-1:0]    n_eff;
  logic [SIZE_W-1:0]   s_eff;
  logic [IN_DATA_W-1:0] mag;
  logic [SIZE_W:0]     trial, diff;
  logic [ENTRY_W-1:0]  head_entry, res_number;
  logic [OFFSET_W-1:0] res_offset;
  status_e             res_status;
  logic [CNT_W:0]      tail_sum;
  logic [CNT_W-1:0]    tail;
  logic                push;

  assign n_eff = eff_count(block_count_q);
  assign s_eff = (block_size_q < MIN_SIZE) ? MIN_SIZE : block_size_q;

  // A configuration write goes first; requests wait for it
  assign s_axis_tready_o = (state_q == S_IDLE) && !cfg_valid_i;
  assign cfg_ready_o     = (state_q == S_IDLE);
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;
  assign cfg_acc         = cfg_valid_i && cfg_ready_o;
  assign commit          = (state_q == S_RESULT) && (!out_valid_q || m_axis_tready_i);

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  // Magnitude of the freed offset
  assign mag = s_axis_tdata_i[IN_DATA_W-1] ? (~s_axis_tdata_i + 1'b1) : s_axis_tdata_i;

  // One restoring division step
  assign trial = {rem_q, quo_q[IN_DATA_W-1]};
  assign diff  = trial - {1'b0, s_eff};

  // Head entry: memory data if written since the rebuild, else its position
  assign head_entry = (head_q < fill_q) ? mem_rdata_q : ENTRY_W'(head_q);

  // Tail position, (head + count) mod N
  assign tail_sum = {1'b0, head_q} + {1'b0, count_q};
  assign tail     = (tail_sum >= {1'b0, n_eff}) ? CNT_W'(tail_sum - {1'b0, n_eff})
                                                : tail_sum[CNT_W-1:0];

  // Result of the request in hand
  always_comb begin
    res_status = ST_OK;
    res_number = '0;
    res_offset = '0;
    push       = 1'b0;
    if (mode_q == MODE_ALLOC) begin
      if (count_q == '0) begin
        res_status = ST_EMPTY;
      end else begin
        res_number = head_entry;
        res_offset = OFFSET_W'(head_entry) * OFFSET_W'(s_eff);
      end
    end else if (null_q) begin
      res_status = ST_NULL;
    end else if (rem_q != '0) begin
      res_status = ST_MISALIGNED;
    end else if ((neg_q && quo_q != '0) || quo_q >= IN_DATA_W'(n_eff)) begin
      res_status = ST_RANGE;
    end else if (count_q >= n_eff) begin
      res_status = ST_FULL;
    end else begin
      res_number = quo_q[ENTRY_W-1:0];
      push       = 1'b1;
    end
  end

  // Memory write on a free commit
  assign mem_we    = commit && push;
  assign mem_waddr = AW'(tail);
  assign mem_wdata = quo_q[ENTRY_W-1:0];

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (s_axis_tuser_i[0] == MODE_FREE && !s_axis_tuser_i[1]) begin
            state_d = S_DIV;
          end else begin
            state_d = S_RESULT;
          end
        end
      end
      S_DIV: begin
        if (step_q == STEP_W'(DIV_STEPS - 1)) state_d = S_RESULT;
      end
      S_RESULT: begin
        if (commit) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Ring pointers, configuration and output register
  always_comb begin
    block_count_d = block_count_q;
    block_size_d  = block_size_q;
    head_d        = head_q;
    count_d       = count_q;
    fill_d        = fill_q;
    out_valid_d   = out_valid_q;
    out_data_d    = out_data_q;

    if (out_valid_q && m_axis_tready_i) out_valid_d = 1'b0;

    if (commit) begin
      if (mode_q == MODE_ALLOC && res_status == ST_OK) begin
        head_d  = (head_q + 1'b1 == n_eff) ? '0 : head_q + 1'b1;
        count_d = count_q - 1'b1;
      end else if (push) begin
        count_d = count_q + 1'b1;
        if (fill_q < n_eff) fill_d = fill_q + 1'b1;
      end
      out_valid_d = 1'b1;
      out_data_d  = {6'b0, count_d, res_status, res_number, res_offset};
    end

    if (cfg_acc) begin
      case (cfg_index_i)
        REG_BLOCK_COUNT: begin
          block_count_d = cfg_data_i[CNT_W-1:0];
          head_d        = '0;
          fill_d        = '0;
          count_d       = eff_count(cfg_data_i[CNT_W-1:0]);
        end
        REG_BLOCK_SIZE: begin
          block_size_d = cfg_data_i;
          head_d       = '0;
          fill_d       = '0;
          count_d      = n_eff;
        end
        default: ;
      endcase
    end
  end

  // Divider datapath
  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    step_d = step_q;
    if (in_acc) begin
      rem_d  = '0;
      quo_d  = mag;
      step_d = '0;
    end else if (state_q == S_DIV) begin
      if (trial >= {1'b0, s_eff}) begin
        rem_d = diff[SIZE_W-1:0];
        quo_d = {quo_q[IN_DATA_W-2:0], 1'b1};
      end else begin
        rem_d = trial[SIZE_W-1:0];
        quo_d = {quo_q[IN_DATA_W-2:0], 1'b0};
      end
      step_d = step_q + 1'b1;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      block_count_q <= BLOCK_COUNT_RST;
      block_size_q  <= BLOCK_SIZE_RST;
      head_q        <= '0;
      count_q       <= RST_COUNT;
      fill_q        <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      block_count_q <= block_count_d;
      block_size_q  <= block_size_d;
      head_q        <= head_d;
      count_q       <= count_d;
      fill_q        <= fill_d;
      out_valid_q   <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
    rem_q      <= rem_d;
    quo_q      <= quo_d;
    step_q     <= step_d;
    if (in_acc) begin
      mode_q <= s_axis_tuser_i[0];
      null_q <= s_axis_tuser_i[1];
      neg_q  <= s_axis_tdata_i[IN_DATA_W-1];
    end
  end

  // Ring memory: one write port, head read every cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) ring_mem[mem_waddr] <= mem_wdata;
    mem_rdata_q <= ring_mem[AW'(head_q)];
  end

endmodule

>>> rtl/fbpa_checker.sv
// Port-level checker for the fixed block pool allocator, with its bind.
`include "fixed_block_pool_allocator_assert.svh"

module fbpa_checker
  import fbpa_pkg::*;
#(
  parameter int unsigned MAX_BLOCKS = 1024
) (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  s_axis_tvalid_i,
  input logic                  s_axis_tready_o,
  input logic                  m_axis_tvalid_o,
  input logic                  m_axis_tready_i,
  input logic [OUT_DATA_W-1:0] m_axis_tdata_o   // [25:0] offset, [35:26] number,
                                                // [38:36] status, [49:39] free_left
);

  // A stalled result holds
  `FBPA_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid_o && !m_axis_tready_i, m_axis_tvalid_o && $stable(m_axis_tdata_o))

  // One request at a time: no acceptance right after one
  `FBPA_ASSERT_NEXT(a_one_inflight, clk_i, rst_ni, s_axis_tvalid_i && s_axis_tready_o, !s_axis_tready_o)

  // Failed or non-ok results carry no block
  `FBPA_ASSERT_NOW(a_fail_zero, clk_i, rst_ni, m_axis_tvalid_o && m_axis_tdata_o[38:36] != ST_OK, m_axis_tdata_o[35:0] == '0)

  // Status code and free count stay in range
  `FBPA_ASSERT_NOW(a_res_range, clk_i, rst_ni, m_axis_tvalid_o, m_axis_tdata_o[38:36] <= ST_FULL && m_axis_tdata_o[49:39] <= MAX_BLOCKS)

endmodule

bind fixed_block_pool_allocator fbpa_checker #(.MAX_BLOCKS(MAX_BLOCKS)) u_fbpa_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);
